// File: rtl/ccoa_pkg.sv
// Shared constants, types and functions of the contact overlap accumulator.
package ccoa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIMS      = 3;
  localparam int CQ        = 30;
  localparam int CSH       = CQ - FRAC_BITS;
  localparam int CW        = FRAC_BITS + 2;
  localparam int SW        = FRAC_BITS + 1;
  localparam int AW        = FRAC_BITS + 2;
  localparam int ZW        = 40;

  localparam logic [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);
  localparam logic [31:0]   INV_PI_Q32  = 32'd1367130551;

  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic [ZW-1:0] atan_q30(input logic [4:0] i);
    logic [ZW-1:0] a;
    unique case (i)
      5'd0:    a = ZW'(64'd843314857);
      5'd1:    a = ZW'(64'd497837830);
      5'd2:    a = ZW'(64'd263043837);
      5'd3:    a = ZW'(64'd133525159);
      5'd4:    a = ZW'(64'd67021687);
      5'd5:    a = ZW'(64'd33543516);
      5'd6:    a = ZW'(64'd16775851);
      5'd7:    a = ZW'(64'd8388437);
      5'd8:    a = ZW'(64'd4194283);
      5'd9:    a = ZW'(64'd2097149);
      5'd10:   a = ZW'(64'd1048576);
      default: a = ZW'(1) << (5'(CQ) - i);
    endcase
    return a;
  endfunction

endpackage

// File: rtl/cell_contact_overlap_accumulator.sv
// Top level of the cell contact overlap accumulator.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   one neighbour pair per beat
//   output   out        out_valid_o / out_ready_i one result per last-marked beat
//
// One pair is worked at a time. A self pair skips all arithmetic; a pair out of
// contact stops at the distance test. A pair in contact runs the 32-step square
// root of the distance, the 17-step cosine division, the 32-step square root for
// the sine and the 30-step CORDIC arccosine in turn on the shared serial units,
// plus the shared 32x32 multiplier. A cap cosine clamped to plus or minus one skips
// the division, and coincident centres or a zero cell radius stop after the first
// root. A last-marked beat adds the serial division by twelve. A finished result
// sits in the output register while the next pair is already taken; only the next
// result waits for it to drain. Reset clears the accumulators and the control.
module cell_contact_overlap_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] cell_index_i,
  input  logic [31:0] neighbour_index_i,
  input  logic signed [31:0] cell_x_i,
  input  logic signed [31:0] cell_y_i,
  input  logic signed [31:0] cell_z_i,
  input  logic [30:0] cell_rad_i,
  input  logic signed [31:0] nbr_x_i,
  input  logic signed [31:0] nbr_y_i,
  input  logic signed [31:0] nbr_z_i,
  input  logic [30:0] nbr_rad_i,
  input  logic        last_neighbour_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] deformable_radius_o,
  output logic [16:0] exposed_surface_o,
  output logic [16:0] exposed_area_o,
  output logic [7:0]  neighbour_count_o
);
  import ccoa_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQ0   = 5'd1;
  localparam logic [4:0] ST_SQ1   = 5'd2;
  localparam logic [4:0] ST_SQ2   = 5'd3;
  localparam logic [4:0] ST_SQ3   = 5'd4;
  localparam logic [4:0] ST_CMP   = 5'd5;
  localparam logic [4:0] ST_ROOT  = 5'd6;
  localparam logic [4:0] ST_RADD  = 5'd7;
  localparam logic [4:0] ST_P0    = 5'd8;
  localparam logic [4:0] ST_P1    = 5'd9;
  localparam logic [4:0] ST_P2    = 5'd10;
  localparam logic [4:0] ST_P3    = 5'd11;
  localparam logic [4:0] ST_COS   = 5'd12;
  localparam logic [4:0] ST_CC    = 5'd13;
  localparam logic [4:0] ST_SIN   = 5'd14;
  localparam logic [4:0] ST_SWAIT = 5'd15;
  localparam logic [4:0] ST_CSTRT = 5'd16;
  localparam logic [4:0] ST_CORD  = 5'd17;
  localparam logic [4:0] ST_TERM  = 5'd18;
  localparam logic [4:0] ST_FIN   = 5'd19;
  localparam logic [4:0] ST_E0    = 5'd20;
  localparam logic [4:0] ST_E1    = 5'd21;
  localparam logic [4:0] ST_E2    = 5'd22;
  localparam logic [4:0] ST_E3    = 5'd23;
  localparam logic [4:0] ST_QDIV  = 5'd24;
  localparam logic [4:0] ST_EMIT  = 5'd25;

  localparam logic [CW-1:0] ONE_Q = CW'(1) << FRAC_BITS;

  logic [4:0] state_q, state_d;

  // Captured pair.
  logic [31:0] mag_q [3];
  logic [30:0] rc_q, rn_q;
  logic        last_q;

  // Accumulators.
  logic signed [47:0] rsum_q;
  logic signed [31:0] asum_q, ssum_q;
  logic [7:0]         cnt_q;

  // Per-pair working registers.
  logic [63:0] prod_q, d2_q, dd_q, drc_q;
  logic        ovf_q;
  logic [31:0] d_q;
  logic signed [CW-1:0] c_q;
  logic [SW-1:0] s_q;
  logic [16:0] fs_q, fa_q;
  logic        qneg_q;
  logic signed [31:0] rad_q;

  // Output register.
  logic        out_valid_q;
  logic signed [31:0] out_rad_q;
  logic [16:0] out_fs_q, out_fa_q;
  logic [7:0]  out_cnt_q;

  logic [31:0] mul_a, mul_b;

  unit_req_t   sq_req, dv_req, co_req;
  unit_sts_t   sq_sts, dv_sts, co_sts;
  logic [63:0] sq_rad, dv_rem, dv_num, dv_den, dv_quot;
  logic [6:0]  dv_steps;
  logic [31:0] sq_root;
  logic [AW-1:0] ang;

  logic        accept;
  logic [31:0] reach;
  logic [CW-1:0] c_abs;
  logic        c_neg;
  logic [31:0] sum_s_abs, sum_a_abs;
  logic [8:0]  k6;
  logic        k6_neg;
  logic [64:0] d2_add;
  logic signed [49:0] rsum_ext;
  logic signed [49:0] q_val;
  logic [49:0] u_val;
  logic [63:0] cos_mag;
  logic        cos_neg;
  logic signed [33:0] term_r;
  logic [32:0] dpr;
  logic [31:0] diff;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign reach      = {1'b0, rc_q} + {1'b0, rn_q};
  assign c_neg      = c_q[CW-1];
  assign c_abs      = c_neg ? CW'(-c_q) : c_q;
  assign sum_s_abs  = ssum_q[31] ? 32'(-ssum_q) : ssum_q;
  assign sum_a_abs  = asum_q[31] ? 32'(-asum_q) : asum_q;
  assign k6_neg     = (cnt_q > 8'd6);
  assign k6         = k6_neg ? 9'({1'b0, cnt_q} - 9'd6) : 9'(9'd6 - {1'b0, cnt_q});
  assign d2_add     = {1'b0, d2_q} + {1'b0, prod_q};
  assign dpr        = {1'b0, d_q} + {2'b0, rc_q};
  assign diff       = (d_q > {1'b0, rc_q}) ? d_q - {1'b0, rc_q} : {1'b0, rc_q} - d_q;

  function automatic logic [31:0] mag_of(input logic signed [31:0] n,
                                         input logic signed [31:0] c);
    logic signed [32:0] dv;
    dv = 33'(n) - 33'(c);
    return dv[32] ? 32'(-dv) : dv[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  // Fraction left free: one minus sum/pi, clamped, then to Q1.16.
  function automatic logic [16:0] free_frac(input logic [63:0] p, input logic neg);
    logic signed [65:0] v;
    logic signed [33:0] lost, f;
    logic signed [33:0] one;
    logic [33:0] g;
    one  = 34'sd1 <<< FRAC_BITS;
    v    = neg ? -$signed({2'b0, p}) : $signed({2'b0, p});
    v    = v + (66'sd1 <<< 31);
    lost = 34'(v >>> 32);
    f    = one - lost;
    if (f < 0)   f = '0;
    if (f > one) f = one;
    if (FRAC_BITS > 16)      g = (f + (34'sd1 <<< (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
    else if (FRAC_BITS < 16) g = f << (16 - FRAC_BITS);
    else                     g = f;
    if (g > 34'd65536) g = 34'd65536;
    return g[16:0];
  endfunction

  // Shared multiplier operands; the product is registered for the next state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ0:  begin mul_a = mag_q[0]; mul_b = mag_q[0]; end
      ST_SQ1:  begin mul_a = mag_q[1]; mul_b = mag_q[1]; end
      ST_SQ2:  begin mul_a = mag_q[2]; mul_b = mag_q[2]; end
      ST_SQ3:  begin mul_a = reach;    mul_b = reach;    end
      ST_P0:   begin mul_a = d_q;      mul_b = d_q;      end
      ST_P1:   begin mul_a = d_q;      mul_b = {1'b0, rc_q}; end
      ST_P2:   begin
        mul_a = (rn_q >= rc_q) ? {1'b0, rn_q - rc_q} : {1'b0, rc_q - rn_q};
        mul_b = reach;
      end
      ST_CC:   begin mul_a = 32'(c_abs); mul_b = 32'(c_abs); end
      ST_CORD: begin mul_a = 32'(c_abs); mul_b = 32'(s_q);   end
      ST_E0:   begin mul_a = {1'b0, rc_q}; mul_b = 32'(k6);  end
      ST_E1:   begin mul_a = sum_s_abs;  mul_b = INV_PI_Q32; end
      ST_E2:   begin mul_a = sum_a_abs;  mul_b = INV_PI_Q32; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Cosine numerator d^2 + rc^2 - rn^2 as magnitude and sign.
  always_comb begin
    cos_neg = 1'b0;
    if (rn_q >= rc_q) begin
      if (dd_q >= prod_q) cos_mag = dd_q - prod_q;
      else begin
        cos_mag = prod_q - dd_q;
        cos_neg = 1'b1;
      end
    end else begin
      cos_mag = dd_q + prod_q;
    end
  end

  assign rsum_ext = 50'(rsum_q);
  assign q_val = rsum_ext
               + (k6_neg ? -$signed({1'b0, prod_q[47:0], 1'b0})
                         : $signed({1'b0, prod_q[47:0], 1'b0}))
               + 50'sd6;
  assign u_val = q_val[49] ? 50'(-q_val + 50'sd11) : q_val;

  // Area term: arccosine minus the rounded product of cosine and sine.
  always_comb begin
    logic signed [63:0] csv, cr;
    csv    = c_neg ? -$signed(prod_q) : $signed(prod_q);
    cr     = (csv + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    term_r = $signed({16'b0, ang}) - 34'(cr);
  end

  // Unit requests and operands.
  always_comb begin
    sq_req.start = 1'b0;
    dv_req.start = 1'b0;
    co_req.start = 1'b0;
    sq_rad   = d2_q;
    dv_rem   = cos_mag;
    dv_num   = '0;
    dv_den   = {drc_q[62:0], 1'b0};
    dv_steps = 7'(FRAC_BITS + 1);
    unique case (state_q)
      ST_CMP:   sq_req.start = !(ovf_q || d2_q >= prod_q);
      ST_SIN: begin
        sq_req.start = 1'b1;
        sq_rad       = (64'd1 << (2 * FRAC_BITS)) - prod_q;
      end
      ST_P3:    dv_req.start = 1'b1;
      ST_E1: begin
        dv_req.start = 1'b1;
        dv_rem       = '0;
        dv_num       = {u_val, 14'b0};
        dv_den       = 64'd12;
        dv_steps     = 7'd50;
      end
      ST_CSTRT: co_req.start = 1'b1;
      default: ;
    endcase
  end

  ccoa_isqrt u_isqrt (
    .clk_i, .rst_ni, .req_i(sq_req), .radicand_i(sq_rad), .sts_o(sq_sts), .root_o(sq_root)
  );

  ccoa_sdiv u_sdiv (
    .clk_i, .rst_ni, .req_i(dv_req), .rem_init_i(dv_rem), .num_i(dv_num), .den_i(dv_den),
    .steps_i(dv_steps), .sts_o(dv_sts), .quot_o(dv_quot)
  );

  ccoa_cordic u_cordic (
    .clk_i, .rst_ni, .req_i(co_req), .cos_i(c_q), .sin_i(s_q), .sts_o(co_sts), .ang_o(ang)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) begin
        state_d = (cell_index_i == neighbour_index_i) ? ST_FIN : ST_SQ0;
      end
      ST_SQ0:   state_d = ST_SQ1;
      ST_SQ1:   state_d = ST_SQ2;
      ST_SQ2:   state_d = ST_SQ3;
      ST_SQ3:   state_d = ST_CMP;
      ST_CMP:   state_d = (ovf_q || d2_q >= prod_q) ? ST_FIN : ST_ROOT;
      ST_ROOT:  if (sq_sts.done) state_d = ST_RADD;
      ST_RADD: begin
        if (d_q == '0 || rc_q == '0)  state_d = ST_FIN;
        else if (diff >= {1'b0, rn_q}) state_d = ST_CC;
        else if (dpr <= {2'b0, rn_q})  state_d = ST_CC;
        else                           state_d = ST_P0;
      end
      ST_P0:    state_d = ST_P1;
      ST_P1:    state_d = ST_P2;
      ST_P2:    state_d = ST_P3;
      ST_P3:    state_d = ST_COS;
      ST_COS:   if (dv_sts.done) state_d = ST_CC;
      ST_CC:    state_d = ST_SIN;
      ST_SIN:   state_d = ST_SWAIT;
      ST_SWAIT: if (sq_sts.done) state_d = ST_CSTRT;
      ST_CSTRT: state_d = ST_CORD;
      ST_CORD:  if (co_sts.done) state_d = ST_TERM;
      ST_TERM:  state_d = ST_FIN;
      ST_FIN:   state_d = last_q ? ST_E0 : ST_IDLE;
      ST_E0:    state_d = ST_E1;
      ST_E1:    state_d = ST_E2;
      ST_E2:    state_d = ST_E3;
      ST_E3:    state_d = ST_QDIV;
      ST_QDIV:  if (dv_sts.done) state_d = ST_EMIT;
      ST_EMIT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rsum_q      <= '0;
      asum_q      <= '0;
      ssum_q      <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new result takes the output register the moment it is free.
      if (state_q == ST_EMIT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i)                      out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (accept && cell_index_i != neighbour_index_i && cnt_q != 8'd255) begin
          cnt_q <= cnt_q + 8'd1;
        end
        ST_SQ0: ovf_q <= 1'b0;
        ST_SQ2, ST_SQ3: if (d2_add[64]) ovf_q <= 1'b1;
        ST_RADD: begin
          logic signed [49:0] rs;
          rs = rsum_ext + 50'({1'b0, d_q}) + 50'({1'b0, rc_q}) - 50'({1'b0, rn_q});
          if (rs > 50'(48'sh7fffffffffff))      rsum_q <= 48'sh7fffffffffff;
          else if (rs < 50'(48'sh800000000000)) rsum_q <= 48'sh800000000000;
          else                                  rsum_q <= rs[47:0];
        end
        ST_TERM: begin
          asum_q <= sat32(50'(asum_q) + 50'(term_r));
          ssum_q <= sat32(50'(ssum_q) + 50'({1'b0, s_q}));
        end
        ST_EMIT: if (!out_valid_q || out_ready_i) begin
          rsum_q      <= '0;
          asum_q      <= '0;
          ssum_q      <= '0;
          cnt_q       <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      mag_q[0] <= mag_of(nbr_x_i, cell_x_i);
      mag_q[1] <= mag_of(nbr_y_i, cell_y_i);
      mag_q[2] <= (DIMS > 2) ? mag_of(nbr_z_i, cell_z_i) : '0;
      rc_q     <= cell_rad_i;
      rn_q     <= nbr_rad_i;
      last_q   <= last_neighbour_i;
    end
    unique case (state_q)
      ST_SQ1:         d2_q <= prod_q;
      ST_SQ2, ST_SQ3: d2_q <= d2_add[63:0];
      ST_ROOT:        if (sq_sts.done) d_q <= sq_root;
      ST_RADD: begin
        if (diff >= {1'b0, rn_q})     c_q <= $signed(ONE_Q);
        else if (dpr <= {2'b0, rn_q}) c_q <= -$signed(ONE_Q);
      end
      ST_P1:          dd_q  <= prod_q;
      ST_P2:          drc_q <= prod_q;
      ST_P3:          qneg_q <= cos_neg;
      ST_COS: if (dv_sts.done) begin
        logic [CW-1:0] q;
        q = CW'((dv_quot[CW-1:0] + CW'(1)) >> 1);
        if (q > ONE_Q) q = ONE_Q;
        c_q <= qneg_q ? $signed(CW'(-q)) : $signed(q);
      end
      ST_SWAIT:       if (sq_sts.done) s_q <= sq_root[SW-1:0];
      ST_E1:          qneg_q <= q_val[49];
      ST_E2:          fs_q <= free_frac(prod_q, ssum_q[31]);
      ST_E3:          fa_q <= free_frac(prod_q, asum_q[31]);
      ST_QDIV: if (dv_sts.done) begin
        rad_q <= sat32(qneg_q ? -$signed({1'b0, dv_quot[48:0]})
                              : $signed({1'b0, dv_quot[48:0]}));
      end
      ST_EMIT: if (!out_valid_q || out_ready_i) begin
        out_rad_q <= rad_q;
        out_fs_q  <= fs_q;
        out_fa_q  <= fa_q;
        out_cnt_q <= cnt_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o         = out_valid_q;
  assign deformable_radius_o = out_rad_q;
  assign exposed_surface_o   = out_fs_q;
  assign exposed_area_o      = out_fa_q;
  assign neighbour_count_o   = out_cnt_q;

endmodule

// File: rtl/ccoa_isqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
module ccoa_isqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccoa_pkg::unit_req_t  req_i,
  input  logic [63:0]          radicand_i,
  output ccoa_pkg::unit_sts_t  sts_o,
  output logic [31:0]          root_o
);
  import ccoa_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] val_q;
  logic [32:0] rem_q;
  logic [31:0] root_q;
  logic [34:0] rem_sh, trial;
  logic        ge;

  assign rem_sh = {rem_q, val_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      val_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[61:0], 2'b00};
      rem_q  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign root_o = root_q;

endmodule

// File: rtl/ccoa_sdiv.sv
// Bit-serial restoring divider with a preset partial remainder.
module ccoa_sdiv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccoa_pkg::unit_req_t  req_i,
  input  logic [63:0]          rem_init_i,
  input  logic [63:0]          num_i,
  input  logic [63:0]          den_i,
  input  logic [6:0]           steps_i,
  output ccoa_pkg::unit_sts_t  sts_o,
  output logic [63:0]          quot_o
);
  import ccoa_pkg::*;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] rem_q, num_q, den_q, quot_q;
  logic [64:0] r2;
  logic        ge;

  assign r2 = {rem_q, num_q[63]};
  assign ge = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= rem_init_i;
      num_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? 64'(r2 - {1'b0, den_q}) : r2[63:0];
      num_q  <= {num_q[62:0], 1'b0};
      quot_q <= {quot_q[62:0], ge};
    end
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;

endmodule

// File: rtl/ccoa_cordic.sv
// Vectoring CORDIC that returns the arccosine of a cosine and sine pair.
module ccoa_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ccoa_pkg::unit_req_t            req_i,
  input  logic signed [ccoa_pkg::CW-1:0] cos_i,
  input  logic [ccoa_pkg::SW-1:0]        sin_i,
  output ccoa_pkg::unit_sts_t            sts_o,
  output logic [ccoa_pkg::AW-1:0]        ang_o
);
  import ccoa_pkg::*;

  logic                 busy_q, done_q;
  logic [4:0]           i_q;
  logic signed [ZW-1:0] x_q, y_q, z_q;
  logic signed [ZW-1:0] xi, yi, xs, ys, a, zr;

  assign xi = ZW'(cos_i) <<< CSH;
  assign yi = $signed(ZW'(sin_i)) <<< CSH;
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign a  = $signed(atan_q30(i_q));
  assign zr = (z_q + (ZW'(1) <<< (CSH - 1))) >>> CSH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(CQ - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      if (cos_i < 0) begin
        x_q <= yi;
        y_q <= -xi;
        z_q <= $signed(HALF_PI_Q30);
      end else begin
        x_q <= xi;
        y_q <= yi;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + a;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - a;
      end
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign ang_o = (zr < 0) ? '0 : zr[AW-1:0];

endmodule

// File: tb/sv/ccoa_checker.sv
// Checker that predicts and compares the results of the contact overlap accumulator.
module ccoa_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [31:0]        cell_index_i,
  input  logic [31:0]        neighbour_index_i,
  input  logic signed [31:0] cell_x_i,
  input  logic signed [31:0] cell_y_i,
  input  logic signed [31:0] cell_z_i,
  input  logic [30:0]        cell_rad_i,
  input  logic signed [31:0] nbr_x_i,
  input  logic signed [31:0] nbr_y_i,
  input  logic signed [31:0] nbr_z_i,
  input  logic [30:0]        nbr_rad_i,
  input  logic               last_neighbour_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] deformable_radius_i,
  input  logic [16:0]        exposed_surface_i,
  input  logic [16:0]        exposed_area_i,
  input  logic [7:0]         neighbour_count_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o
);
  import ccoa_pkg::*;

  typedef struct packed {
    logic signed [31:0] radius;
    logic [16:0]        surface;
    logic [16:0]        area;
    logic [7:0]         count;
  } cell_result_t;

  localparam longint RSUM_HI = 64'sd140737488355327;
  localparam longint RSUM_LO = -64'sd140737488355328;

  cell_result_t result_q[$];
  longint radius_sum, area_sum, surface_sum;
  int unsigned nbr_count;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Restoring division of mag by den, one extra bit for rounding.
  function automatic longint cap_cosine(longint unsigned mag, bit neg, longint unsigned den);
    longint unsigned rem, q;
    rem = mag;
    q = 0;
    for (int k = 0; k <= FRAC_BITS; k++) begin
      q <<= 1;
      if (rem >= den - rem) begin
        rem -= den - rem;
        q |= 1;
      end else begin
        rem += rem;
      end
    end
    q = (q + 1) >> 1;
    if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint atan_tab(int i);
    case (i)
      0: return 843314857;   1: return 497837830;   2: return 263043837;
      3: return 133525159;   4: return 67021687;    5: return 33543516;
      6: return 16775851;    7: return 8388437;     8: return 4194283;
      9: return 2097149;     default: return 1048576;
    endcase
  endfunction

  function automatic longint cap_angle(longint c, longint s);
    longint x, y, z, t, a, xs, ys;
    x = c <<< CSH;
    y = s <<< CSH;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = longint'(HALF_PI_Q30);
    end
    for (int i = 0; i < CQ; i++) begin
      a = (i < 11) ? longint'(atan_tab(i)) : (64'sd1 <<< (CQ - i));
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += a;
      end else begin
        x -= ys;
        y += xs;
        z -= a;
      end
    end
    t = (z + (64'sd1 <<< (CSH - 1))) >>> CSH;
    return t < 0 ? 0 : t;
  endfunction

  function automatic logic [16:0] open_fraction(longint sum);
    longint one, lost, f;
    one = 64'sd1 <<< FRAC_BITS;
    lost = (sum * 64'sd1367130551 + (64'sd1 <<< 31)) >>> 32;
    f = one - lost;
    if (f < 0) f = 0;
    if (f > one) f = one;
    if (FRAC_BITS > 16) f = (f + (64'sd1 <<< (FRAC_BITS - 17))) >>> (FRAC_BITS - 16);
    else if (FRAC_BITS < 16) f = f <<< (16 - FRAC_BITS);
    if (f > 65536) f = 65536;
    return 17'(f);
  endfunction

  task automatic add_pair();
    longint unsigned rc, rn, d2, reach, d, diff, sq, m, dd, den, t, mag;
    longint dv, c, s, term, one;
    bit neg, ovf;
    rc = cell_rad_i;
    rn = nbr_rad_i;
    one = 64'sd1 <<< FRAC_BITS;
    d2 = 0;
    ovf = 0;
    if (nbr_count < 255) nbr_count++;
    for (int k = 0; k < DIMS && k < 3; k++) begin
      case (k)
        0: dv = longint'(nbr_x_i) - longint'(cell_x_i);
        1: dv = longint'(nbr_y_i) - longint'(cell_y_i);
        default: dv = longint'(nbr_z_i) - longint'(cell_z_i);
      endcase
      m = dv < 0 ? -dv : dv;
      sq = m * m;
      if (d2 > 64'hFFFF_FFFF_FFFF_FFFF - sq) ovf = 1;
      if (!ovf) d2 += sq;
    end
    if (ovf) return;
    reach = rc + rn;
    if (d2 >= reach * reach) return;
    d = int_sqrt(d2);
    radius_sum += longint'(rc) - longint'(rn) + longint'(d);
    if (radius_sum > RSUM_HI) radius_sum = RSUM_HI;
    if (radius_sum < RSUM_LO) radius_sum = RSUM_LO;
    // Coincident centres or a point cell add no cap terms.
    if (d == 0 || rc == 0) return;
    diff = d > rc ? d - rc : rc - d;
    if (diff >= rn) begin
      c = one;
    end else if (d + rc <= rn) begin
      c = -one;
    end else begin
      dd = d * d;
      den = 2 * d * rc;
      neg = 0;
      if (rn >= rc) begin
        t = (rn - rc) * (rn + rc);
        if (dd >= t) begin
          mag = dd - t;
        end else begin
          mag = t - dd;
          neg = 1;
        end
      end else begin
        mag = dd + (rc - rn) * (rc + rn);
      end
      c = cap_cosine(mag, neg, den);
    end
    s = longint'(int_sqrt((64'd1 << (2 * FRAC_BITS)) - longint'(c * c)));
    term = cap_angle(c, s) - ((c * s + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    area_sum = clip32(area_sum + term);
    surface_sum = clip32(surface_sum + s);
  endtask

  task automatic close_cell();
    cell_result_t r;
    longint q, rc;
    rc = cell_rad_i;
    q = radius_sum + 2 * rc * (6 - longint'(nbr_count)) + 6;
    q = (q >= 0) ? q / 12 : -((-q + 11) / 12);
    r.radius = 32'(clip32(q));
    r.surface = open_fraction(surface_sum);
    r.area = open_fraction(area_sum);
    r.count = 8'(nbr_count);
    result_q.push_back(r);
    radius_sum = 0;
    area_sum = 0;
    surface_sum = 0;
    nbr_count = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t e;
    if (!rst_ni) begin
      result_q.delete();
      radius_sum = 0;
      area_sum = 0;
      surface_sum = 0;
      nbr_count = 0;
      fail_count_o = 0;
      result_count_o = 0;
      pending_o = 0;
    end else begin
      // Results are checked before the input beat of the same edge is booked.
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          e = result_q.pop_front();
          if (deformable_radius_i !== e.radius) begin
            $error("deformable_radius exp %0d got %0d", e.radius, deformable_radius_i);
            fail_count_o++;
          end
          if (exposed_surface_i !== e.surface) begin
            $error("exposed_surface exp %0d got %0d", e.surface, exposed_surface_i);
            fail_count_o++;
          end
          if (exposed_area_i !== e.area) begin
            $error("exposed_area exp %0d got %0d", e.area, exposed_area_i);
            fail_count_o++;
          end
          if (neighbour_count_i !== e.count) begin
            $error("neighbour_count exp %0d got %0d", e.count, neighbour_count_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (cell_index_i != neighbour_index_i) add_pair();
        if (last_neighbour_i) close_cell();
      end
      pending_o = result_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the testbench: clock, reset, pair stimulus and the verdict.
module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [31:0]        cell_index_i = '0;
  logic [31:0]        neighbour_index_i = '0;
  logic signed [31:0] cell_x_i = '0;
  logic signed [31:0] cell_y_i = '0;
  logic signed [31:0] cell_z_i = '0;
  logic [30:0]        cell_rad_i = '0;
  logic signed [31:0] nbr_x_i = '0;
  logic signed [31:0] nbr_y_i = '0;
  logic signed [31:0] nbr_z_i = '0;
  logic [30:0]        nbr_rad_i = '0;
  logic               last_neighbour_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] deformable_radius_o;
  logic [16:0]        exposed_surface_o;
  logic [16:0]        exposed_area_o;
  logic [7:0]         neighbour_count_o;

  int fail_count, pending, result_count;
  int beats_sent;
  longint cycle_count;
  bit calm_phase;

  // Worst case: every pair on its longest path plus the closing division, the longest
  // sender gap and the longest receiver stall, taken several times over.
  localparam longint CYCLE_LIMIT = 1400 * 250 * 4;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cell_contact_overlap_accumulator dut (.*);

  ccoa_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .cell_index_i, .neighbour_index_i, .cell_x_i, .cell_y_i, .cell_z_i, .cell_rad_i,
    .nbr_x_i, .nbr_y_i, .nbr_z_i, .nbr_rad_i, .last_neighbour_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .deformable_radius_i(deformable_radius_o),
    .exposed_surface_i(exposed_surface_o),
    .exposed_area_i(exposed_area_o),
    .neighbour_count_i(neighbour_count_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the calm final part.
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 9);
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Drives one beat and holds it until it is taken. Gaps, if any, come first.
  task automatic send_pair(logic [31:0] ci, logic [31:0] ni,
                           logic signed [31:0] cx, cy, cz, logic [30:0] cr,
                           logic signed [31:0] nx, ny, nz, logic [30:0] nr, logic last);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_index_i <= ci;
    neighbour_index_i <= ni;
    cell_x_i <= cx;
    cell_y_i <= cy;
    cell_z_i <= cz;
    cell_rad_i <= cr;
    nbr_x_i <= nx;
    nbr_y_i <= ny;
    nbr_z_i <= nz;
    nbr_rad_i <= nr;
    last_neighbour_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // A neighbour placed near the cell so that contact is likely, with
  // a neighbour radius of zero to four units (Q16.16).
  task automatic send_near(logic [31:0] ci, logic signed [31:0] cx, cy, cz,
                           logic [30:0] cr, logic last);
    int span;
    logic [31:0] ni;
    span = 32'($urandom_range(1, 4)) << 16;
    ni = ($urandom_range(0, 15) == 0) ? ci : $urandom;
    send_pair(ci, ni, cx, cy, cz, cr,
              cx + $signed($urandom_range(0, 2 * span)) - span,
              cy + $signed($urandom_range(0, 2 * span)) - span,
              cz + $signed($urandom_range(0, 2 * span)) - span,
              31'($urandom_range(0, 4 << 16)), last);
  endtask

  initial begin
    logic signed [31:0] cx, cy, cz;
    logic [30:0] cr;
    logic [31:0] ci;
    int n, wait_cycles;
    beats_sent = 0;
    calm_phase = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs: a self pair as the last beat, coincident centres, a zero
    // cell radius, one sphere inside the other, a touching pair, huge
    // coordinates that overflow the squared distance, and field extremes.
    send_pair(5, 5, 0, 0, 0, 31'h10000, 0, 0, 0, 31'h10000, 1);
    send_pair(1, 2, 0, 0, 0, 31'h10000, 0, 0, 0, 31'h8000, 0);
    send_pair(1, 3, 0, 0, 0, 31'h0, 32'h8000, 0, 0, 31'h10000, 0);
    send_pair(1, 4, 0, 0, 0, 31'h10000, 32'h4000, 0, 0, 31'h40000, 0);
    send_pair(1, 6, 0, 0, 0, 31'h40000, 32'h4000, 0, 0, 31'h10000, 0);
    send_pair(1, 7, 0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000, 0);
    send_pair(1, 8, 0, 0, 0, 31'h10000, 32'h18000, 32'h4000, 0, 31'h10000, 1);
    send_pair('1, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 0);
    send_pair('0, '1, 32'h8000_0000, 32'h7FFF_FFFF, 0, '1,
              32'h7FFF_FFFF, 32'h8000_0000, 0, '1, 0);
    send_pair(9, 10, 0, 0, 0, '1, 32'h1, 32'h1, 32'h1, '1, 0);
    send_pair(9, 11, -32'sd65536, 0, 32'h7000, 31'h18000, 32'h8000, 32'h4000, 0,
              31'h14000, 1);
    // More than six contacts drive 6-n negative.
    for (int k = 0; k < 9; k++)
      send_pair(20, 21 + k, 0, 0, 0, 31'h20000, 32'h10000 * (k % 3),
                32'h8000 * (k % 2), -32'sd16384, 31'h18000, k == 8);

    // Random cells: mostly clustered neighbour lists, some wide random noise.
    while (beats_sent < 1200) begin
      if (beats_sent > 1050) calm_phase = 1;
      ci = $urandom;
      cx = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 1 << 20));
      cy = $urandom;
      cz = $urandom_range(0, 3) == 0 ? 32'sd0 : 32'($urandom);
      cr = 31'($urandom_range(0, 3 << 16));
      n = $urandom_range(0, 3) == 0 ? $urandom_range(8, 14) : $urandom_range(1, 7);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_pair($urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom),
                    $urandom, $urandom, $urandom, 31'($urandom), k == n - 1);
        else
          send_near(ci, cx, cy, cz, cr, k == n - 1);
      end
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(posedge clk_i);
    $display("Sent %0d pair beats across clustered, overlapping, self and far pairs;",
             beats_sent);
    $display("%0d cell results were compared, %0d mismatches.", result_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
